// ----- design/positional_array_list_defines.svh -----
// Assertion macros for the positional array list.
`ifndef POSITIONAL_ARRAY_LIST_DEFINES_SVH
`define POSITIONAL_ARRAY_LIST_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define PAL_AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define PAL_AST_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/pal_pkg.sv -----
package pal_pkg;

    localparam int DEPTH = 1024;
    localparam int IDX_W = $clog2(DEPTH);

    localparam int REQ_W = 2;
    localparam int POS_W = 11;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int CNT_W = 11;

    typedef logic [REQ_W-1:0] t_req;
    typedef logic [ST_W-1:0]  t_status;
    typedef logic [1:0]       t_op;

    localparam t_req REQ_INSERT = 2'd0;
    localparam t_req REQ_DELETE = 2'd1;
    localparam t_req REQ_READ   = 2'd2;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_NOPOS = 2'd2;

    localparam t_op OP_HOLD = 2'd0;
    localparam t_op OP_INS  = 2'd1;
    localparam t_op OP_DEL  = 2'd2;
    localparam t_op OP_READ = 2'd3;

    typedef struct packed {
        t_op                     op;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] value;
    } t_cell_ctl;

endpackage

// ----- design/pal_if.sv -----
interface pal_req_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_req                    req_type;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, req_type, position, value, input ready);
    modport sink   (input valid, req_type, position, value, output ready);
endinterface

interface pal_rsp_if import pal_pkg::*; ();
    logic                    valid;
    logic                    ready;
    t_status                 status;
    logic signed [VAL_W-1:0] read_value;
    logic [CNT_W-1:0]        count;

    modport source (output valid, status, read_value, count, input ready);
    modport sink   (input valid, status, read_value, count, output ready);
endinterface

// ----- design/pal_cell.sv -----
module pal_cell import pal_pkg::*; (
    input  logic                    i_clk,
    input  logic [IDX_W-1:0]        i_idx,
    input  t_cell_ctl               i_ctl,
    input  logic signed [VAL_W-1:0] i_left_data,
    input  logic signed [VAL_W-1:0] i_right_data,
    input  logic signed [VAL_W-1:0] i_right_rd,
    output logic signed [VAL_W-1:0] o_data,
    output logic signed [VAL_W-1:0] o_rd
);

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] r_rd;
    logic signed [VAL_W-1:0] n_data;
    logic signed [VAL_W-1:0] n_rd;
    logic [POS_W-1:0]        w_idx;

    assign w_idx = POS_W'(i_idx);

    always_comb begin
        n_data = r_data;
        n_rd   = i_right_rd;
        case (i_ctl.op)
            OP_INS: begin
                if (w_idx == i_ctl.pos) begin
                    n_data = i_ctl.value;
                end else if (w_idx > i_ctl.pos) begin
                    n_data = i_left_data;
                end
            end
            OP_DEL: begin
                if (w_idx >= i_ctl.pos) begin
                    n_data = i_right_data;
                end
            end
            OP_READ: begin
                if (w_idx == i_ctl.pos) begin
                    n_rd = r_data;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_rd   <= n_rd;
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

// ----- design/positional_array_list.sv -----
// channel | dir | words carried
// i_req   | in  | req_type, position, value
// o_rsp   | out | status, read_value, count
//
// Insert, delete, refused and unused requests: the result is registered as the word is
// taken; an accepted insert or delete shifts the cells from the position up in that cycle.
// Read: the word walks one cell a cycle down the read chain to cell 0, then is registered.
// One request at a time; a new word is taken when idle and the output register is empty
// or being drained in the same cycle.
// Synchronous reset empties the list (count zero) and the output register; cells keep junk.
`include "positional_array_list_defines.svh"

module positional_array_list import pal_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pal_req_if.sink   i_req,
    pal_rsp_if.source o_rsp
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic                    r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic [IDX_W-1:0]        r_left;
    logic                    r_ovalid;
    t_status                 r_status;
    logic signed [VAL_W-1:0] r_rdval;
    logic [CNT_W-1:0]        r_ocnt;

    logic [CNT_W-1:0]        n_cnt;
    logic                    w_acc;
    t_status                 w_status;
    t_op                     w_op;
    t_cell_ctl               w_ctl;

    logic signed [VAL_W-1:0] w_data [0:DEPTH+1];
    logic signed [VAL_W-1:0] w_rd   [0:DEPTH];

    assign i_req.ready = i_rst_n && (r_state == ST_IDLE) && (!r_ovalid || o_rsp.ready);
    assign w_acc       = i_req.valid && i_req.ready;

    always_comb begin
        w_status = ST_OK;
        w_op     = OP_HOLD;
        n_cnt    = r_cnt;
        if (w_acc) begin
            case (i_req.req_type)
                REQ_INSERT: begin
                    if (r_cnt == CNT_W'(DEPTH)) begin
                        w_status = ST_FULL;
                    end else if (i_req.position > POS_W'(r_cnt)) begin
                        w_status = ST_NOPOS;
                    end else begin
                        w_op  = OP_INS;
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                REQ_DELETE: begin
                    if (i_req.position >= POS_W'(r_cnt)) begin
                        w_status = ST_NOPOS;
                    end else begin
                        w_op  = OP_DEL;
                        n_cnt = r_cnt - CNT_W'(1);
                    end
                end
                REQ_READ: begin
                    if (i_req.position >= POS_W'(r_cnt)) begin
                        w_status = ST_NOPOS;
                    end else begin
                        w_op = OP_READ;
                    end
                end
                default: ;
            endcase
        end
    end

    assign w_ctl.op    = w_op;
    assign w_ctl.pos   = i_req.position;
    assign w_ctl.value = i_req.value;

    assign w_data[0]       = '0;
    assign w_data[DEPTH+1] = '0;
    assign w_rd[DEPTH]     = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        pal_cell u_cell (
            .i_clk        (i_clk),
            .i_idx        (IDX_W'(g)),
            .i_ctl        (w_ctl),
            .i_left_data  (w_data[g]),
            .i_right_data (w_data[g+2]),
            .i_right_rd   (w_rd[g+1]),
            .o_data       (w_data[g+1]),
            .o_rd         (w_rd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (w_acc && w_op == OP_READ) begin
                r_state  <= ST_READ;
                r_ovalid <= 1'b0;
            end else if (w_acc) begin
                r_ovalid <= 1'b1;
            end else if (r_state == ST_READ && r_left == '0) begin
                r_state  <= ST_IDLE;
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_op == OP_READ) begin
            r_left <= i_req.position[IDX_W-1:0];
        end else if (r_state == ST_READ) begin
            r_left <= r_left - IDX_W'(1);
        end
        if (w_acc) begin
            r_status <= w_status;
            r_rdval  <= '0;
            r_ocnt   <= n_cnt;
        end else if (r_state == ST_READ && r_left == '0) begin
            r_status <= ST_OK;
            r_rdval  <= w_rd[0];
            r_ocnt   <= r_cnt;
        end
    end

    assign o_rsp.valid      = r_ovalid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_rdval;
    assign o_rsp.count      = r_ocnt;

    `PAL_AST_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CNT_W'(DEPTH), "count above depth")
    `PAL_AST_NXT(a_ins_cnt, i_clk, i_rst_n, w_acc && w_op == OP_INS, r_cnt == $past(r_cnt) + CNT_W'(1), "insert count")
    `PAL_AST_IMP(a_read_busy, i_clk, i_rst_n, r_state == ST_READ, !w_acc && !r_ovalid, "word taken during read")
    `PAL_AST_NXT(a_read_done, i_clk, i_rst_n, r_state == ST_READ && r_left == '0, r_ovalid && r_state == ST_IDLE, "read not finished")

endmodule
